// File: rtl/core/pfc_pkg.sv
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int LANE_W   = 38;
  localparam int ANG_W    = 26;
  localparam int SQ_STEPS = 29;
  localparam int R_W      = 36;

  localparam logic signed [R_W-1:0] R_ONE     = 36'sd268435456;
  localparam logic signed [R_W-1:0] R_NEG_ONE = -36'sd268435456;
  localparam logic signed [22:0]    RAD2DEG   = 23'sd3754936;
  localparam logic signed [26:0]    ANG_LIMIT = 27'sd23040;
  localparam logic signed [ANG_W-1:0] ANG_90  = 26'sd5898240;

  typedef struct packed {
    logic [2:0]         flags;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] pos_right;
    logic signed [31:0] pos_upward;
    logic signed [31:0] pos_back;
    logic [47:0]        lin_vel_in;
    logic [47:0]        ang_vel_in;
  } in_t;

  typedef struct packed {
    logic               pose_valid;
    logic signed [31:0] pos_forward;
    logic signed [31:0] pos_left;
    logic signed [31:0] pos_up;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic [47:0]        lin_vel_out;
    logic [47:0]        ang_vel_out;
  } out_t;

  typedef struct packed {
    logic               pose_valid;
    logic signed [31:0] pos_forward;
    logic signed [31:0] pos_left;
    logic signed [31:0] pos_up;
    logic [47:0]        lin_vel_out;
    logic [47:0]        ang_vel_out;
  } side_t;

  typedef struct packed {
    logic                     zero;
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } lane_t;

  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    return (v == 32'sh80000000) ? 32'sh7fffffff : -v;
  endfunction

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  function automatic lane_t cord_pre(input logic signed [LANE_W-1:0] x,
                                     input logic signed [LANE_W-1:0] y);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = ANG_90;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -ANG_90;
      end
    end
    return l;
  endfunction

  function automatic lane_t cord_step(input lane_t l, input logic [4:0] idx);
    lane_t r;
    logic signed [LANE_W-1:0] dx;
    logic signed [LANE_W-1:0] dy;
    dx = l.y >>> idx;
    dy = l.x >>> idx;
    r.zero = l.zero;
    if (l.y >= 0) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + atan_deg(idx);
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - atan_deg(idx);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_q9_7(input lane_t l, input logic neg);
    logic signed [26:0] a;
    a = (27'(l.z) + 27'sd256) >>> 9;
    if (neg) a = -a;
    if (l.zero) a = '0;
    if (a > ANG_LIMIT) a = ANG_LIMIT;
    if (a < -ANG_LIMIT) a = -ANG_LIMIT;
    return a[15:0];
  endfunction

  function automatic logic [15:0] ang_round(input logic signed [40:0] p);
    logic signed [40:0] s;
    s = (p + 41'sd8388608) >>> 24;
    if (s > 41'sd32767) s = 41'sd32767;
    if (s < -41'sd32768) s = -41'sd32768;
    return s[15:0];
  endfunction

endpackage

// File: rtl/core/pose_frame_converter_unit.sv
`timescale 1ns / 1ps
// channel | valid    | ready     | word
// in      | in_valid | in_ready  | in_word  (in_t)
// out     | out_valid| out_ready | out_word (out_t)
// One word per cycle sustained while the output is not stalled.
// Latency is set by the bit-serial square root (29 stages) and the CORDIC stages.
// All stages advance together; a stalled output holds the whole pipeline in place.
// Synchronous reset clears the valid bits only.
module pose_frame_converter_unit import pfc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_word,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_word
);

  localparam int CS = CORDIC_STEPS;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // stage A: products
  logic v_a;
  logic signed [31:0] m_yy, m_zz, m_xy, m_wz, m_xz, m_wy, m_xx, m_yz, m_wx;
  logic signed [40:0] ap0, ap1, ap2;
  logic [2:0] flg_a;
  logic signed [31:0] pf_a, pl_a, pu_a;
  logic [47:0] lin_a;

  always_ff @(posedge clk) begin
    if (rst) v_a <= 1'b0;
    else if (adv) v_a <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_yy <= 32'(in_word.quat_y) * 32'(in_word.quat_y);
      m_zz <= 32'(in_word.quat_z) * 32'(in_word.quat_z);
      m_xy <= 32'(in_word.quat_x) * 32'(in_word.quat_y);
      m_wz <= 32'(in_word.quat_w) * 32'(in_word.quat_z);
      m_xz <= 32'(in_word.quat_x) * 32'(in_word.quat_z);
      m_wy <= 32'(in_word.quat_w) * 32'(in_word.quat_y);
      m_xx <= 32'(in_word.quat_x) * 32'(in_word.quat_x);
      m_yz <= 32'(in_word.quat_y) * 32'(in_word.quat_z);
      m_wx <= 32'(in_word.quat_w) * 32'(in_word.quat_x);
      ap0 <= (-41'(signed'(in_word.ang_vel_in[47:32]))) * 41'(RAD2DEG);
      ap1 <= (-41'(signed'(in_word.ang_vel_in[15:0]))) * 41'(RAD2DEG);
      ap2 <= 41'(signed'(in_word.ang_vel_in[31:16])) * 41'(RAD2DEG);
      flg_a <= in_word.flags;
      pf_a <= neg_sat32(in_word.pos_back);
      pl_a <= neg_sat32(in_word.pos_right);
      pu_a <= in_word.pos_upward;
      lin_a <= {in_word.lin_vel_in[31:16],
                neg_sat16(signed'(in_word.lin_vel_in[15:0])),
                neg_sat16(signed'(in_word.lin_vel_in[47:32]))};
    end
  end

  // stage B: matrix entries
  logic v_b;
  logic signed [R_W-1:0] r00, r01, r02, r11, r21;
  logic signed [29:0] a_b;
  lane_t pit_b, yaw_b;
  side_t side_b;
  logic pv_a, vv_a;

  assign r00 = R_ONE - ((36'(m_yy) + 36'(m_zz)) <<< 1);
  assign r01 = (36'(m_xy) - 36'(m_wz)) <<< 1;
  assign r02 = (36'(m_xz) + 36'(m_wy)) <<< 1;
  assign r11 = R_ONE - ((36'(m_xx) + 36'(m_zz)) <<< 1);
  assign r21 = (36'(m_yz) + 36'(m_wx)) <<< 1;
  assign pv_a = (flg_a[1:0] == 2'b11);
  assign vv_a = pv_a && flg_a[2];

  always_ff @(posedge clk) begin
    if (rst) v_b <= 1'b0;
    else if (adv) v_b <= v_a;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pit_b <= '{zero: 1'b0, x: LANE_W'(r11), y: -LANE_W'(r21), z: '0};
      yaw_b <= '{zero: 1'b0, x: LANE_W'(r00), y: -LANE_W'(r02), z: '0};
      if (r01 > R_ONE) a_b <= 30'(R_ONE);
      else if (r01 < R_NEG_ONE) a_b <= 30'(R_NEG_ONE);
      else a_b <= 30'(r01);
      side_b.pose_valid <= pv_a;
      side_b.pos_forward <= pv_a ? pf_a : '0;
      side_b.pos_left <= pv_a ? pl_a : '0;
      side_b.pos_up <= pv_a ? pu_a : '0;
      side_b.lin_vel_out <= vv_a ? lin_a : '0;
      side_b.ang_vel_out <= vv_a ? {ang_round(ap2), ang_round(ap1), ang_round(ap0)} : '0;
    end
  end

  // stage C: 1 - a*a, then square root stages
  logic [28:0] a_mag;
  assign a_mag = a_b[29] ? 29'(-a_b) : a_b[28:0];

  logic        sq_vld [0:SQ_STEPS];
  logic [56:0] sq_v   [0:SQ_STEPS];
  logic [57:0] sq_r   [0:SQ_STEPS];
  lane_t       sq_p   [0:SQ_STEPS];
  lane_t       sq_y   [0:SQ_STEPS];
  logic signed [29:0] sq_a [0:SQ_STEPS];
  side_t       sq_s   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= v_b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0] <= 57'(58'd1 << 56) - 57'(a_mag * a_mag);
      sq_r[0] <= '0;
      sq_p[0] <= pit_b;
      sq_y[0] <= yaw_b;
      sq_a[0] <= a_b;
      sq_s[0] <= side_b;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [57:0] BIT = 58'd1 << (56 - 2 * k);
    logic [57:0] t;
    logic        ge;
    assign t  = sq_r[k] + BIT;
    assign ge = {1'b0, sq_v[k]} >= t;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (adv) sq_vld[k+1] <= sq_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v[k+1] <= ge ? 57'({1'b0, sq_v[k]} - t) : sq_v[k];
        sq_r[k+1] <= ge ? (sq_r[k] >> 1) + BIT : sq_r[k] >> 1;
        sq_p[k+1] <= sq_p[k];
        sq_y[k+1] <= sq_y[k];
        sq_a[k+1] <= sq_a[k];
        sq_s[k+1] <= sq_s[k];
      end
    end
  end

  // CORDIC: lane 0 pitch, lane 1 yaw, lane 2 roll
  logic  cd_vld [0:CS];
  lane_t cd_l   [0:CS][0:2];
  side_t cd_s   [0:CS];

  always_ff @(posedge clk) begin
    if (rst) cd_vld[0] <= 1'b0;
    else if (adv) cd_vld[0] <= sq_vld[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_l[0][0] <= cord_pre(sq_p[SQ_STEPS].x, sq_p[SQ_STEPS].y);
      cd_l[0][1] <= cord_pre(sq_y[SQ_STEPS].x, sq_y[SQ_STEPS].y);
      cd_l[0][2] <= cord_pre(LANE_W'(sq_r[SQ_STEPS]), LANE_W'(sq_a[SQ_STEPS]));
      cd_s[0] <= sq_s[SQ_STEPS];
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cd_vld[i+1] <= 1'b0;
      else if (adv) cd_vld[i+1] <= cd_vld[i];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int j = 0; j < 3; j++) begin
          cd_l[i+1][j] <= cord_step(cd_l[i][j], 5'(i));
        end
        cd_s[i+1] <= cd_s[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= cd_vld[CS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.pose_valid  <= cd_s[CS].pose_valid;
      out_word.pos_forward <= cd_s[CS].pos_forward;
      out_word.pos_left    <= cd_s[CS].pos_left;
      out_word.pos_up      <= cd_s[CS].pos_up;
      out_word.lin_vel_out <= cd_s[CS].lin_vel_out;
      out_word.ang_vel_out <= cd_s[CS].ang_vel_out;
      out_word.pitch <= cd_s[CS].pose_valid ? to_q9_7(cd_l[CS][0], 1'b0) : '0;
      out_word.yaw   <= cd_s[CS].pose_valid ? to_q9_7(cd_l[CS][1], 1'b1) : '0;
      out_word.roll  <= cd_s[CS].pose_valid ? to_q9_7(cd_l[CS][2], 1'b0) : '0;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.pose_valid |-> out_word.pitch == '0 && out_word.yaw == '0 &&
      out_word.roll == '0 && out_word.ang_vel_out == '0 && out_word.pos_up == '0)
    else $error("invalid pose word not cleared");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.pitch <= 16'sd23040 && out_word.pitch >= -16'sd23040 &&
      out_word.yaw <= 16'sd23040 && out_word.yaw >= -16'sd23040 &&
      out_word.roll <= 16'sd23040 && out_word.roll >= -16'sd23040)
    else $error("angle out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cd_vld[CS]) && $stable(sq_vld[SQ_STEPS]) && $stable(v_a))
    else $error("pipeline moved during stall");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pfc_pkg::*;

  localparam int STEPS = 16;
  localparam int RANDOM_WORDS = 1300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLDOFF_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_word;

  pose_frame_converter_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  out_t pose_q[$];
  int errors = 0;
  int got_count = 0;
  int stall_cycles = 0;

  const longint ATAN_Q16[24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  localparam longint ONE28 = 64'sd1 <<< 28;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint neg_clip(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return clip(-v, -hi - 1, hi);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint atan2_deg(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 64'sd90 <<< 16;
      end else begin
        x = -y;
        y = t;
        z = -(64'sd90 <<< 16);
      end
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] deg_q97(longint zq, bit negate);
    longint a;
    a = (zq + 256) >>> 9;
    if (negate) a = -a;
    a = clip(a, -23040, 23040);
    return a[15:0];
  endfunction

  function automatic logic [15:0] rad_to_deg(longint v);
    longint p;
    p = v * 3754936;
    p = clip((p + (64'sd1 <<< 23)) >>> 24, -32768, 32767);
    return p[15:0];
  endfunction

  function automatic longint lane(logic [47:0] v, int k);
    logic signed [15:0] s;
    s = v[16*k +: 16];
    return longint'(s);
  endfunction

  function automatic out_t convert_pose(in_t p);
    out_t o;
    longint w, x, y, z, r00, r01, r02, r11, r21, a, c, t;
    o = '0;
    if (p.flags[1:0] != 2'b11) return o;
    o.pose_valid = 1'b1;
    t = neg_clip(longint'(p.pos_back), 32);
    o.pos_forward = t[31:0];
    t = neg_clip(longint'(p.pos_right), 32);
    o.pos_left = t[31:0];
    o.pos_up = p.pos_upward;
    w = longint'(p.quat_w);
    x = longint'(p.quat_x);
    y = longint'(p.quat_y);
    z = longint'(p.quat_z);
    r00 = ONE28 - 2 * (y * y + z * z);
    r01 = 2 * (x * y - w * z);
    r02 = 2 * (x * z + w * y);
    r11 = ONE28 - 2 * (x * x + z * z);
    r21 = 2 * (y * z + w * x);
    o.pitch = deg_q97(atan2_deg(-r21, r11), 1'b0);
    o.yaw = deg_q97(atan2_deg(-r02, r00), 1'b1);
    a = clip(r01, -ONE28, ONE28);
    c = longint'(root64(longint'(ONE28 * ONE28) - a * a));
    o.roll = deg_q97(atan2_deg(a, c), 1'b0);
    if (p.flags[2]) begin
      o.lin_vel_out = {16'(lane(p.lin_vel_in, 1)), 16'(neg_clip(lane(p.lin_vel_in, 0), 16)),
                       16'(neg_clip(lane(p.lin_vel_in, 2), 16))};
      o.ang_vel_out = {rad_to_deg(lane(p.ang_vel_in, 1)), rad_to_deg(-lane(p.ang_vel_in, 0)),
                       rad_to_deg(-lane(p.ang_vel_in, 2))};
    end
    return o;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch word %0d %s: got %h expected %h", got_count, field, got, want);
  endtask

  task automatic check_word(out_t got, out_t want);
    if (got.pose_valid !== want.pose_valid)
      report("pose_valid", 64'(got.pose_valid), 64'(want.pose_valid));
    if (got.pos_forward !== want.pos_forward)
      report("pos_forward", 64'(unsigned'(got.pos_forward)), 64'(unsigned'(want.pos_forward)));
    if (got.pos_left !== want.pos_left)
      report("pos_left", 64'(unsigned'(got.pos_left)), 64'(unsigned'(want.pos_left)));
    if (got.pos_up !== want.pos_up)
      report("pos_up", 64'(unsigned'(got.pos_up)), 64'(unsigned'(want.pos_up)));
    if (got.pitch !== want.pitch)
      report("pitch", 64'(unsigned'(got.pitch)), 64'(unsigned'(want.pitch)));
    if (got.yaw !== want.yaw)
      report("yaw", 64'(unsigned'(got.yaw)), 64'(unsigned'(want.yaw)));
    if (got.roll !== want.roll)
      report("roll", 64'(unsigned'(got.roll)), 64'(unsigned'(want.roll)));
    if (got.lin_vel_out !== want.lin_vel_out)
      report("lin_vel_out", 64'(got.lin_vel_out), 64'(want.lin_vel_out));
    if (got.ang_vel_out !== want.ang_vel_out)
      report("ang_vel_out", 64'(got.ang_vel_out), 64'(want.ang_vel_out));
  endtask

  // directed table: word, and whether the expected result is typed in
  typedef struct {
    in_t word;
    bit known;
    out_t want;
  } row_t;
  row_t rows[$];

  function automatic in_t mk(logic [2:0] f, int w, int x, int y, int z, logic [31:0] pr,
                             logic [31:0] pu, logic [31:0] pb, logic [47:0] lv,
                             logic [47:0] av);
    in_t p;
    p.flags = f;
    p.quat_w = 16'(w);
    p.quat_x = 16'(x);
    p.quat_y = 16'(y);
    p.quat_z = 16'(z);
    p.pos_right = pr;
    p.pos_upward = pu;
    p.pos_back = pb;
    p.lin_vel_in = lv;
    p.ang_vel_in = av;
    return p;
  endfunction

  task automatic add_row(in_t p, bit known);
    row_t r;
    r.word = p;
    r.known = known;
    r.want = '0;
    rows.push_back(r);
  endtask

  function automatic int rand_quat();
    if ($urandom_range(19) == 0) return $urandom_range(1) ? 16384 : -16384;
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic logic [47:0] rand_vel();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    for (int k = 0; k < 3; k++)
      if ($urandom_range(9) == 0) v[16*k +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    return v;
  endfunction

  function automatic logic [31:0] rand_pos();
    if ($urandom_range(19) == 0) return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
    return $urandom;
  endfunction

  function automatic in_t rand_word();
    logic [2:0] f;
    f = 3'($urandom_range(7));
    if ($urandom_range(4) != 0) f[1:0] = 2'b11;
    return mk(f, rand_quat(), rand_quat(), rand_quat(), rand_quat(), rand_pos(), rand_pos(),
              rand_pos(), rand_vel(), rand_vel());
  endfunction

  task automatic send_word(in_t p, bit known, out_t want);
    in_valid <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (!in_ready);
    pose_q.push_back(known ? want : convert_pose(p));
    @(negedge clk);
  endtask

  initial begin
    int total;
    add_row(mk(3'd0, 16384, 0, 0, 0, 32'd5, 32'd6, 32'd7, 48'h123456789abc, 48'h1), 1);
    add_row(mk(3'd1, 16384, 0, 0, 0, 32'd5, 32'd6, 32'd7, 48'h1, 48'h1), 1);
    add_row(mk(3'd2, 16384, 0, 0, 0, 32'd5, 32'd6, 32'd7, 48'h1, 48'h1), 1);
    add_row(mk(3'd6, -16384, 1, 2, 3, 32'h80000000, 32'd6, 32'd7, 48'hffff, 48'h8000), 1);
    add_row(mk(3'd7, 16384, 0, 0, 0, 32'd1, 32'd2, 32'd3, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, -16384, 0, 0, 0, 32'd1, 32'd2, 32'd3, 48'h1_0002_0003, 48'h1_0002_0003), 0);
    add_row(mk(3'd7, 0, 16384, 0, 0, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, -16384, 0, 0, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, 0, 16384, 0, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, 0, -16384, 0, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, 0, 0, 16384, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, 0, 0, -16384, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd3, 0, 0, 0, 0, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 0, 8192, 0, 8192, 32'd9, 32'd9, 32'd9, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 16384, 16384, 16384, -16384, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 16384, 16384, -16384, 16384, 32'd0, 32'd0, 32'd0, 48'h0, 48'h0), 0);
    add_row(mk(3'd7, 11585, 0, 0, 11585, 32'h80000000, 32'h80000000, 32'h80000000,
               48'h8000_8000_8000, 48'h8000_8000_8000), 0);
    add_row(mk(3'd7, 11585, 11585, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff), 0);
    add_row(mk(3'd3, 8000, -9000, 7000, -6000, 32'hffffffff, 32'h1, 32'hdeadbeef,
               48'hffff_ffff_ffff, 48'hffff_ffff_ffff), 0);
    add_row(mk(3'd7, -8000, 9000, -7000, 6000, 32'h0, 32'hffffffff, 32'h1,
               48'h0001_ffff_0001, 48'h0123_fedc_0800), 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    total = rows.size() + RANDOM_WORDS;
    for (int n = 0; n < total; n++) begin
      if (n == rows.size() + 900) begin
        in_valid <= 1'b0;
        while (pose_q.size() != 0) @(negedge clk);
      end
      if ((n < 500 || n > 700) && $urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      if (n < rows.size()) send_word(rows[n].word, rows[n].known, rows[n].want);
      else send_word(rand_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held && got_count >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      out_ready <= ((got_count >= 500 && got_count <= 700) || $urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        errors++;
        $display("unexpected word %0d", got_count);
      end else begin
        check_word(out_word, pose_q.pop_front());
      end
      got_count++;
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
